>>> hw/rtl/fpba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_pkg: shared definitions of the fit-policy block allocator
// Constants, codes and the control structures between controller and datapath.
// ----------------------------------------------------------------------------
package fpba_pkg;

	localparam int MAX_BLOCKS_DEF = 16;
	localparam int SIZE_BITS_DEF  = 16;

	localparam int IDX_W    = 4;
	localparam int FIELD_W  = 16;
	localparam int STAT_W   = 2;
	localparam int POL_W    = 2;
	localparam int COUNT_W  = 5;
	localparam int CFG_W    = 5;
	localparam int CFG_IDX_W = 1;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 24;

	localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
	localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
	localparam logic [POL_W-1:0] POL_WORST = 2'd2;

	localparam logic [STAT_W-1:0] ST_LOADED    = 2'd0;
	localparam logic [STAT_W-1:0] ST_ALLOCATED = 2'd1;
	localparam logic [STAT_W-1:0] ST_NO_ALLOC  = 2'd2;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_ALLOC = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd1;

	localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 5'd16;

	typedef struct packed {
		logic load;
		logic start;
		logic rd_en;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic scan_more;
		logic out_free;
	} ctl_stat_t;

	function automatic int addr_bits(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

>>> hw/rtl/fpba_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fpba_ram #(
	parameter int WIDTH = fpba_pkg::SIZE_BITS_DEF,
	parameter int DEPTH = fpba_pkg::MAX_BLOCKS_DEF,
	localparam int AW = fpba_pkg::addr_bits(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/fpba_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_ctrl: allocator controller
// Accepts words, sequences the table scan and the write-back of an allocation.
// ----------------------------------------------------------------------------
module fpba_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tuser,
	output logic                s_tready,
	input  fpba_pkg::ctl_stat_t stat,
	output fpba_pkg::ctl_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign s_tready = (state_q == ST_IDLE) && stat.out_free;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (s_tuser == fpba_pkg::CMD_ALLOC) begin
						cmd.start = 1'b1;
						state_d   = ST_SCAN;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				cmd.rd_en = stat.scan_more;
				if (!stat.scan_more) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hw/rtl/fpba_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_dp: allocator datapath
// Configuration registers, free-size table, scan compare and result register.
// ----------------------------------------------------------------------------
module fpba_dp #(
	parameter int MAX_BLOCKS = fpba_pkg::MAX_BLOCKS_DEF,
	parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [fpba_pkg::S_TDATA_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [fpba_pkg::M_TDATA_W-1:0]      m_tdata,
	output logic [fpba_pkg::STAT_W-1:0]         m_tuser,
	input  logic                                cfg_we,
	input  logic [fpba_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fpba_pkg::CFG_W-1:0]          cfg_wdata,
	input  fpba_pkg::ctl_cmd_t                  cmd,
	output fpba_pkg::ctl_stat_t                 stat
);

	localparam int AW = fpba_pkg::addr_bits(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int LW = (CW > fpba_pkg::COUNT_W) ? CW : fpba_pkg::COUNT_W;
	localparam int IW = (AW > fpba_pkg::IDX_W) ? AW : fpba_pkg::IDX_W;
	localparam int FW = (SIZE_BITS > fpba_pkg::FIELD_W) ? SIZE_BITS : fpba_pkg::FIELD_W;

	logic [fpba_pkg::IDX_W-1:0]   in_idx;
	logic [fpba_pkg::FIELD_W-1:0] in_load;
	logic [fpba_pkg::FIELD_W-1:0] in_req;
	logic [IW-1:0]                idx_w;
	logic [FW-1:0]                load_w;
	logic [FW-1:0]                req_w;
	logic                         idx_ok;

	logic [fpba_pkg::POL_W-1:0]   policy_q;
	logic [fpba_pkg::COUNT_W-1:0] count_q;

	logic [LW-1:0]        bc_w;
	logic [LW-1:0]        lim_w;
	logic [CW-1:0]        limit_q;
	logic [CW-1:0]        cnt_q;
	logic [SIZE_BITS-1:0] req_q;
	logic                 rd_ok_s1;
	logic [AW-1:0]        rd_idx_s1;
	logic                 found_q;
	logic [SIZE_BITS-1:0] best_q;
	logic [AW-1:0]        best_idx_q;

	logic [SIZE_BITS-1:0] rd_data;
	logic                 fits;
	logic                 take;
	logic [SIZE_BITS-1:0] diff;
	logic [FW-1:0]        frag_w;
	logic [IW-1:0]        best_idx_w;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [SIZE_BITS-1:0] ram_wdata;

	logic                          out_valid_q;
	logic [fpba_pkg::STAT_W-1:0]   out_status_q;
	logic [fpba_pkg::IDX_W-1:0]    out_block_q;
	logic [fpba_pkg::FIELD_W-1:0]  out_frag_q;

	assign in_idx  = s_tdata[3:0];
	assign in_load = s_tdata[19:4];
	assign in_req  = s_tdata[35:20];
	assign idx_w   = IW'(in_idx);
	assign load_w  = FW'(in_load);
	assign req_w   = FW'(in_req);
	assign idx_ok  = 32'(in_idx) < 32'(MAX_BLOCKS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= fpba_pkg::POL_FIRST;
			count_q  <= fpba_pkg::BLOCK_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fpba_pkg::REG_FIT_POLICY: begin
					policy_q <= cfg_wdata[fpba_pkg::POL_W-1:0];
				end
				fpba_pkg::REG_BLOCK_COUNT: begin
					count_q <= cfg_wdata;
				end
			endcase
		end
	end

	assign bc_w  = LW'(count_q);
	assign lim_w = (bc_w > LW'(MAX_BLOCKS)) ? LW'(MAX_BLOCKS) : bc_w;

	assign stat.scan_more = cnt_q < limit_q;
	assign stat.out_free  = !out_valid_q || m_tready;

	fpba_ram #(
		.WIDTH(SIZE_BITS),
		.DEPTH(MAX_BLOCKS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.rd_en),
		.raddr(cnt_q[AW-1:0]),
		.rdata(rd_data)
	);

	assign fits = rd_data >= req_q;

	always_comb begin
		take = 1'b0;
		if (rd_ok_s1 && fits) begin
			if (!found_q) begin
				take = 1'b1;
			end else begin
				unique case (policy_q)
					fpba_pkg::POL_BEST:  take = rd_data < best_q;
					fpba_pkg::POL_WORST: take = rd_data > best_q;
					default:             take = 1'b0;
				endcase
			end
		end
	end

	assign diff       = best_q - req_q;
	assign frag_w     = FW'(diff);
	assign best_idx_w = IW'(best_idx_q);

	assign ram_we    = (cmd.load && idx_ok) || (cmd.finish && found_q);
	assign ram_waddr = cmd.finish ? best_idx_q : idx_w[AW-1:0];
	assign ram_wdata = cmd.finish ? diff : load_w[SIZE_BITS-1:0];

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_q   <= req_w[SIZE_BITS-1:0];
			limit_q <= lim_w[CW-1:0];
		end
		if (cmd.rd_en) begin
			rd_idx_s1 <= cnt_q[AW-1:0];
		end
		if (take) begin
			best_q     <= rd_data;
			best_idx_q <= rd_idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			rd_ok_s1 <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			rd_ok_s1 <= cmd.rd_en;
			if (cmd.start) begin
				cnt_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (cmd.rd_en) begin
					cnt_q <= cnt_q + CW'(1);
				end
				if (take) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_status_q <= fpba_pkg::ST_LOADED;
			out_block_q  <= '0;
			out_frag_q   <= '0;
		end else if (cmd.finish) begin
			if (found_q) begin
				out_status_q <= fpba_pkg::ST_ALLOCATED;
				out_block_q  <= best_idx_w[fpba_pkg::IDX_W-1:0];
				out_frag_q   <= frag_w[fpba_pkg::FIELD_W-1:0];
			end else begin
				out_status_q <= fpba_pkg::ST_NO_ALLOC;
				out_block_q  <= '0;
				out_frag_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load || cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {4'd0, out_frag_q, out_block_q};

endmodule

>>> hw/rtl/fit_policy_block_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_unit: first, best and worst fit block allocator
// Top level joining the controller and the datapath with its free-size table.
// ----------------------------------------------------------------------------
// A load word writes one block's free size. An allocate word scans blocks
// 0 to N-1, with N the smaller of block_count and MAX_BLOCKS, reading one
// table entry per cycle from the single read port of the table RAM, then
// writes the chosen block back and posts the result. The table holds garbage
// after reset, so every block that an allocation will search must be loaded
// first. The result sits in a single output register, and a new word is taken
// only while that register is empty or is being read in the same cycle, so an
// output side that holds off stalls the input.
module fit_policy_block_allocator_unit #(
	parameter int MAX_BLOCKS = fpba_pkg::MAX_BLOCKS_DEF,
	parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// block_index[3:0], load_size[19:4], request_size[35:20]
	input  logic [fpba_pkg::S_TDATA_W-1:0] s_tdata,
	// cmd[0]
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// block_number[3:0], fragment[19:4]
	output logic [fpba_pkg::M_TDATA_W-1:0] m_tdata,
	// status[1:0]
	output logic [fpba_pkg::STAT_W-1:0]    m_tuser,
	input  logic                           cfg_we,
	input  logic [fpba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fpba_pkg::CFG_W-1:0]     cfg_wdata
);

	fpba_pkg::ctl_cmd_t  ctl_cmd;
	fpba_pkg::ctl_stat_t ctl_stat;

	fpba_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tuser (s_tuser),
		.s_tready(s_tready),
		.stat    (ctl_stat),
		.cmd     (ctl_cmd)
	);

	fpba_dp #(
		.MAX_BLOCKS(MAX_BLOCKS),
		.SIZE_BITS (SIZE_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cmd      (ctl_cmd),
		.stat     (ctl_stat)
	);

`ifndef SYNTHESIS
	a_finish_slot_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_cmd.finish |-> !m_tvalid)
		else $error("Allocation finished while the output register was full.");

	a_finish_posts_word: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_cmd.finish || ctl_cmd.load) |=> m_tvalid)
		else $error("A finished item did not post a result word.");

	a_alloc_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser) |=> !s_tready)
		else $error("Input accepted while an allocation was in progress.");

	a_scan_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_cmd.rd_en |-> !s_tready)
		else $error("Table scan overlapped with input acceptance.");
`endif

endmodule
